// ----- hdl/priority_queue_age_drop_defines.svh -----
// Assertion macros shared by the priority queue RTL.
`ifndef PRIORITY_QUEUE_AGE_DROP_DEFINES_SVH
`define PRIORITY_QUEUE_AGE_DROP_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define PQAD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("priority queue check failed");

// Next-cycle implication, disabled while reset is active.
`define PQAD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("priority queue check failed");

`endif

// ----- hdl/pqad_pkg.sv -----
// Package with the types, codes and defaults of the priority queue.
package pqad_pkg;

    // Default queue depth and reset value of the drop age register.
    localparam int          QUEUE_DEPTH_DEF = 16;
    localparam logic [15:0] DROP_AGE_RST    = 16'd10000;

    // Request codes.
    localparam logic [1:0] REQ_ENQ  = 2'd0;
    localparam logic [1:0] REQ_DEQ  = 2'd1;
    localparam logic [1:0] REQ_TICK = 2'd2;

    // Result status codes.
    localparam logic [2:0] STS_SERVED  = 3'd0;
    localparam logic [2:0] STS_DISCARD = 3'd1;
    localparam logic [2:0] STS_EMPTY   = 3'd2;
    localparam logic [2:0] STS_ACCEPT  = 3'd3;
    localparam logic [2:0] STS_REJECT  = 3'd4;

    // One queue entry as it is held in the memory.
    typedef struct packed {
        logic [15:0] id;
        logic        prio;
        logic [31:0] stamp;
    } t_entry;

endpackage

// ----- hdl/pqad_ram.sv -----
// Generic single-write, single-read RAM with a registered read.
module pqad_ram
    import pqad_pkg::*;
#(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/priority_queue_age_drop.sv -----
// Top level of the two-class job queue with discard of aged normal jobs.
//
//  channel   direction  handshake                 payload
//  request   in         i_in_valid / o_in_stall   i_req_type, i_priority_req
//  result    out        o_out_valid / i_out_stall o_status, o_job_id,
//                                                 o_job_priority, o_occupancy
//  config    in         i_cfg_wr_en               i_cfg_wr_data (drop age)
//
// A tick only advances the time and gives no result. A dequeue of n jobs
// walks all n entries, one memory read a cycle, to pick the job; then the
// entries behind it move up by one, a read and a write each cycle.
// Reset is synchronous and clears only the control state; the entry memory
// needs no clearing pass, as only entries below the count are ever used.
// A finished result waits in the output register while the next request beat
// is taken; a result still pending behind a stalled output holds the input.
`include "priority_queue_age_drop_defines.svh"

module priority_queue_age_drop
    import pqad_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic        i_priority_req,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [15:0] o_job_id,
    output logic        o_job_priority,
    output logic [4:0]  o_occupancy,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data
);

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_SEL   = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    // Ranking of a dequeue candidate; a higher rank wins.
    localparam logic [1:0] RANK_HEAD = 2'd0;
    localparam logic [1:0] RANK_HIGH = 2'd1;
    localparam logic [1:0] RANK_AGED = 2'd2;

    logic [2:0]    r_state,      n_state;
    logic [CW-1:0] r_count,      n_count;
    logic [31:0]   r_time,       n_time;
    logic [15:0]   r_next_id,    n_next_id;
    logic [15:0]   r_drop_age;
    logic [IW-1:0] r_chk_idx,    n_chk_idx;
    logic [IW-1:0] r_wr_idx,     n_wr_idx;
    logic [IW-1:0] r_pick_idx,   n_pick_idx;
    logic [1:0]    r_pick_rank,  n_pick_rank;
    logic [15:0]   r_pick_id,    n_pick_id;
    logic          r_pick_prio,  n_pick_prio;
    logic [2:0]    r_res_status, n_res_status;
    logic [15:0]   r_res_id,     n_res_id;
    logic          r_res_prio,   n_res_prio;
    logic          r_out_valid,  n_out_valid;
    logic [2:0]    r_out_status, n_out_status;
    logic [15:0]   r_out_id,     n_out_id;
    logic          r_out_prio,   n_out_prio;
    logic [4:0]    r_out_occ,    n_out_occ;

    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [IW-1:0] ram_raddr;
    t_entry        ram_wdata;
    t_entry        ram_rdata;

    logic          in_acc;
    logic          out_free;
    logic          full;
    logic [31:0]   age;
    logic          aged;
    logic [1:0]    cand_rank;

    // Entry memory: id, priority and time stamp of each queued job.
    pqad_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Handshake terms.
    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign full       = (r_count == CW'(QUEUE_DEPTH));

    // Classification of the entry whose read data arrives this cycle.
    assign age       = r_time - ram_rdata.stamp;
    assign aged      = !ram_rdata.prio && (age >= {16'd0, r_drop_age});
    assign cand_rank = aged ? RANK_AGED : (ram_rdata.prio ? RANK_HIGH : RANK_HEAD);

    // Sequencer: accept, scan, select, compact and hand over the result.
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_time       = r_time;
        n_next_id    = r_next_id;
        n_chk_idx    = r_chk_idx;
        n_wr_idx     = r_wr_idx;
        n_pick_idx   = r_pick_idx;
        n_pick_rank  = r_pick_rank;
        n_pick_id    = r_pick_id;
        n_pick_prio  = r_pick_prio;
        n_res_status = r_res_status;
        n_res_id     = r_res_id;
        n_res_prio   = r_res_prio;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_id     = r_out_id;
        n_out_prio   = r_out_prio;
        n_out_occ    = r_out_occ;

        ram_we    = 1'b0;
        ram_waddr = IW'(r_count);
        ram_wdata = '{id: r_next_id, prio: i_priority_req, stamp: r_time};
        ram_raddr = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                ram_raddr = '0;
                if (in_acc) begin
                    unique case (i_req_type)
                        REQ_ENQ: begin
                            if (full) begin
                                n_res_status = STS_REJECT;
                                n_res_id     = '0;
                                n_res_prio   = 1'b0;
                            end else begin
                                ram_we       = 1'b1;
                                n_count      = r_count + CW'(1);
                                n_next_id    = r_next_id + 16'd1;
                                n_res_status = STS_ACCEPT;
                                n_res_id     = r_next_id;
                                n_res_prio   = i_priority_req;
                            end
                            n_state = S_FIN;
                        end
                        REQ_DEQ: begin
                            if (r_count == '0) begin
                                n_res_status = STS_EMPTY;
                                n_res_id     = '0;
                                n_res_prio   = 1'b0;
                                n_state      = S_FIN;
                            end else begin
                                n_chk_idx   = '0;
                                n_pick_rank = RANK_HEAD;
                                n_state     = S_SCAN;
                            end
                        end
                        REQ_TICK: begin
                            n_time = r_time + 32'd1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // The head is the fallback; a better rank found first wins.
                ram_raddr = r_chk_idx + IW'(1);
                if ((r_chk_idx == '0) || (cand_rank > r_pick_rank)) begin
                    n_pick_idx  = r_chk_idx;
                    n_pick_rank = cand_rank;
                    n_pick_id   = ram_rdata.id;
                    n_pick_prio = ram_rdata.prio;
                end
                if (CW'(r_chk_idx) + CW'(1) == r_count) begin
                    n_state = S_SEL;
                end else begin
                    n_chk_idx = r_chk_idx + IW'(1);
                end
            end
            S_SEL: begin
                ram_raddr    = r_pick_idx + IW'(1);
                n_wr_idx     = r_pick_idx;
                n_res_status = (r_pick_rank == RANK_AGED) ? STS_DISCARD : STS_SERVED;
                n_res_id     = r_pick_id;
                n_res_prio   = r_pick_prio;
                if (CW'(r_pick_idx) + CW'(1) == r_count) begin
                    n_count = r_count - CW'(1);
                    n_state = S_FIN;
                end else begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                // Move the entry behind the gap up by one place.
                ram_we    = 1'b1;
                ram_waddr = r_wr_idx;
                ram_wdata = ram_rdata;
                ram_raddr = r_wr_idx + IW'(2);
                n_wr_idx  = r_wr_idx + IW'(1);
                if (CW'(r_wr_idx) + CW'(2) == r_count) begin
                    n_count = r_count - CW'(1);
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_id     = r_res_id;
                    n_out_prio   = r_res_prio;
                    n_out_occ    = 5'(r_count);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers, cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_time      <= '0;
            r_next_id   <= '0;
            r_drop_age  <= DROP_AGE_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_time      <= n_time;
            r_next_id   <= n_next_id;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_drop_age <= i_cfg_wr_data;
            end
        end
    end

    // Payload and scan registers, no reset needed.
    always_ff @(posedge i_clk) begin
        r_chk_idx    <= n_chk_idx;
        r_wr_idx     <= n_wr_idx;
        r_pick_idx   <= n_pick_idx;
        r_pick_rank  <= n_pick_rank;
        r_pick_id    <= n_pick_id;
        r_pick_prio  <= n_pick_prio;
        r_res_status <= n_res_status;
        r_res_id     <= n_res_id;
        r_res_prio   <= n_res_prio;
        r_out_status <= n_out_status;
        r_out_id     <= n_out_id;
        r_out_prio   <= n_out_prio;
        r_out_occ    <= n_out_occ;
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_job_id       = r_out_id;
    assign o_job_priority = r_out_prio;
    assign o_occupancy    = r_out_occ;

    // Checks on the queue bookkeeping.
    `PQAD_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(QUEUE_DEPTH))
    `PQAD_ASSERT_IMP(a_pick_in_range, i_clk, i_rst_n, r_state == S_SEL,
                     CW'(r_pick_idx) < r_count)
    `PQAD_ASSERT_IMP(a_shift_in_range, i_clk, i_rst_n, r_state == S_SHIFT,
                     CW'(r_wr_idx) + CW'(2) <= r_count)
    `PQAD_ASSERT_NXT(a_enq_grows, i_clk, i_rst_n, in_acc && (i_req_type == REQ_ENQ) && !full,
                     r_count == $past(r_count) + CW'(1))
    `PQAD_ASSERT_IMP(a_discard_low, i_clk, i_rst_n,
                     r_out_valid && (r_out_status == STS_DISCARD), !r_out_prio)

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the two-class job queue with discard of aged normal jobs.
module testbench;
    import pqad_pkg::*;

    localparam int         DEPTH         = QUEUE_DEPTH_DEF;
    // The request code with no meaning: the block ignores it.
    localparam logic [1:0] REQ_NONE      = 2'd3;
    // A dequeue of a full queue walks all depth entries and compacts up to depth - 1 of them.
    localparam int         SETTLE_CYCLES = 2 * DEPTH + 8;
    localparam int         IDLE_PERCENT  = 28;
    localparam int         DRAIN_LIMIT   = 20000;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] job_id;
        logic        job_priority;
        logic [4:0]  occupancy;
    } t_job_result;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_req_type     = REQ_TICK;
    logic        i_priority_req = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall    = 1'b0;
    logic [2:0]  o_status;
    logic [15:0] o_job_id;
    logic        o_job_priority;
    logic [4:0]  o_occupancy;
    logic        i_cfg_wr_en    = 1'b0;
    logic [15:0] i_cfg_wr_data  = 16'd0;

    // Own copy of the queue, the tick clock, the id counter and the drop age.
    logic [15:0] q_ids   [DEPTH];
    logic        q_prio  [DEPTH];
    logic [31:0] q_stamp [DEPTH];
    int          q_count    = 0;
    logic [31:0] now_ticks  = 32'd0;
    logic [15:0] id_next    = 16'd0;
    logic [15:0] age_limit  = DROP_AGE_RST;

    t_job_result pending_results[$];
    int          fail_count    = 0;
    bit          send_idling   = 1'b0;
    bit          recv_idling   = 1'b0;
    int          hold_request  = 0;
    int          stall_left    = 0;

    priority_queue_age_drop uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_priority_req (i_priority_req),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_job_id       (o_job_id),
        .o_job_priority (o_job_priority),
        .o_occupancy    (o_occupancy),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Remove one entry and close the gap, keeping the order of the rest.
    function automatic void take_out(input int pos);
        for (int k = pos; k + 1 < q_count; k++) begin
            q_ids[k]   = q_ids[k + 1];
            q_prio[k]  = q_prio[k + 1];
            q_stamp[k] = q_stamp[k + 1];
        end
        q_count--;
    endfunction

    // Applies one request to the queue copy; returns 1 when it yields a result.
    function automatic bit queue_outcome(input logic [1:0] req, input logic prio,
                                         output t_job_result res);
        int          pick;
        bit          found;
        logic [31:0] age;
        res   = '0;
        pick  = 0;
        found = 1'b0;
        case (req)
            REQ_ENQ: begin
                if (q_count >= DEPTH) begin
                    res.status = STS_REJECT;
                end else begin
                    q_ids[q_count]   = id_next;
                    q_prio[q_count]  = prio;
                    q_stamp[q_count] = now_ticks;
                    q_count++;
                    res.status       = STS_ACCEPT;
                    res.job_id       = id_next;
                    res.job_priority = prio;
                    id_next          = id_next + 16'd1;
                end
            end
            REQ_DEQ: begin
                if (q_count == 0) begin
                    res.status = STS_EMPTY;
                end else begin
                    // An aged normal job is discarded in preference to serving anything.
                    for (int i = 0; i < q_count; i++) begin
                        age = now_ticks - q_stamp[i];
                        if (!found && !q_prio[i] && age >= {16'd0, age_limit}) begin
                            pick  = i;
                            found = 1'b1;
                        end
                    end
                    if (found) begin
                        res.status = STS_DISCARD;
                    end else begin
                        res.status = STS_SERVED;
                        for (int i = 0; i < q_count; i++) begin
                            if (!found && q_prio[i]) begin
                                pick  = i;
                                found = 1'b1;
                            end
                        end
                    end
                    res.job_id       = q_ids[pick];
                    res.job_priority = q_prio[pick];
                    take_out(pick);
                end
            end
            REQ_TICK: begin
                now_ticks = now_ticks + 32'd1;
                return 1'b0;
            end
            default: return 1'b0;
        endcase
        res.occupancy = q_count[4:0];
        return 1'b1;
    endfunction

    // Offers one request beat and waits until it is taken.
    task automatic send_req(input logic [1:0] req, input logic prio);
        t_job_result res;
        if (send_idling) begin
            while ($urandom_range(0, 99) < IDLE_PERCENT) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid     <= 1'b1;
        i_req_type     <= req;
        i_priority_req <= prio;
        do @(posedge i_clk); while (o_in_stall);
        if (queue_outcome(req, prio, res))
            pending_results = {pending_results, res};
    endtask

    // Stops offering and waits until every expected result has come back.
    task automatic wait_for_results();
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_results.size() != 0) begin
            fail_count++;
            $display("%0t: %0d expected results never arrived", $time,
                     pending_results.size());
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_drop_age(input logic [15:0] value);
        wait_for_results();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        age_limit      = value;
    endtask

    task automatic send_ticks(input int count);
        for (int n = 0; n < count; n++)
            send_req(REQ_TICK, 1'($urandom_range(0, 1)));
    endtask

    // Receiver: long hold-offs on request, otherwise random stalls while recv_idling is set.
    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            stall_left   = hold_request;
            hold_request = 0;
        end
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else if (recv_idling) begin
            i_out_stall <= ($urandom_range(0, 99) < IDLE_PERCENT);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (act_v !== exp_v) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v,
                     act_v);
        end
    endtask

    // Each result beat is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_job_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result, expected none, got status %0d id %0d",
                         $time, o_status, o_job_id);
            end else begin
                want = pending_results.pop_front();
                check_field("status", 16'(want.status), 16'(o_status));
                check_field("job_id", want.job_id, o_job_id);
                check_field("job_priority", 16'(want.job_priority), 16'(o_job_priority));
                check_field("occupancy", 16'(want.occupancy), 16'(o_occupancy));
            end
        end
    end

    // Empty queue, unused code, and high jobs overtaking normal ones.
    task automatic test_empty_and_classes();
        send_req(REQ_DEQ, 1'b0);
        send_req(REQ_DEQ, 1'b1);
        send_req(REQ_ENQ, 1'b0);
        send_req(REQ_ENQ, 1'b1);
        send_req(REQ_ENQ, 1'b0);
        send_req(REQ_ENQ, 1'b1);
        send_req(REQ_NONE, 1'b1);
        send_req(REQ_NONE, 1'b0);
        repeat (5) send_req(REQ_DEQ, 1'b0);
        wait_for_results();
    endtask

    // Under the reset drop age a short wait discards nothing; the high job goes first.
    task automatic test_default_drop_age();
        send_req(REQ_ENQ, 1'b0);
        send_req(REQ_ENQ, 1'b0);
        send_req(REQ_ENQ, 1'b1);
        send_ticks(40);
        send_req(REQ_DEQ, 1'b0);
        send_req(REQ_DEQ, 1'b0);
        send_ticks(1);
        send_req(REQ_DEQ, 1'b1);
        wait_for_results();
    endtask

    // Fill to the brim, get rejections, then empty it again.
    task automatic test_full_queue();
        repeat (DEPTH) send_req(REQ_ENQ, 1'($urandom_range(0, 1)));
        send_req(REQ_ENQ, 1'b1);
        send_req(REQ_ENQ, 1'b0);
        repeat (DEPTH + 1) send_req(REQ_DEQ, 1'b0);
        wait_for_results();
    endtask

    // Smallest and largest drop ages; high jobs are never discarded.
    task automatic test_drop_age_limits();
        set_drop_age(16'd0);
        send_req(REQ_ENQ, 1'b1);
        send_req(REQ_ENQ, 1'b0);
        send_req(REQ_ENQ, 1'b0);
        repeat (3) send_req(REQ_DEQ, 1'b0);
        set_drop_age(16'd1);
        send_req(REQ_ENQ, 1'b0);
        send_req(REQ_DEQ, 1'b0);
        send_req(REQ_ENQ, 1'b0);
        send_req(REQ_ENQ, 1'b1);
        send_ticks(1);
        send_req(REQ_DEQ, 1'b0);
        send_req(REQ_DEQ, 1'b0);
        set_drop_age(16'hFFFF);
        send_req(REQ_ENQ, 1'b0);
        send_ticks(3);
        send_req(REQ_DEQ, 1'b0);
        wait_for_results();
    endtask

    // Receiver holds off while requests keep coming, then the sender waits for all.
    task automatic test_backpressure();
        set_drop_age(16'd5);
        hold_request = 300;
        for (int n = 0; n < 48; n++) begin
            case ($urandom_range(0, 3))
                0, 1: send_req(REQ_ENQ, 1'($urandom_range(0, 1)));
                2:    send_req(REQ_DEQ, 1'($urandom_range(0, 1)));
                default: send_req(REQ_TICK, 1'($urandom_range(0, 1)));
            endcase
        end
        wait_for_results();
    endtask

    // Random request mix over several drop ages and idling settings.
    task automatic test_random();
        logic [15:0] ages [5];
        int          items;
        int          r;
        logic [1:0]  req;
        ages[0] = 16'd1;
        ages[1] = 16'($urandom_range(3, 40));
        ages[2] = 16'hFFFF;
        ages[3] = 16'($urandom_range(8, 60));
        ages[4] = 16'($urandom_range(2, 12));
        for (int phase = 0; phase < 5; phase++) begin
            set_drop_age(ages[phase]);
            send_idling = (phase != 2);
            recv_idling = (phase != 2) && (phase != 4);
            items = 0;
            while (items < 220) begin
                r = $urandom_range(0, 99);
                if (r < 5)
                    req = REQ_NONE;
                else if (r < 45)
                    req = REQ_ENQ;
                else if (r < 75)
                    req = REQ_DEQ;
                else
                    req = REQ_TICK;
                send_req(req, 1'($urandom_range(0, 1)));
                if (req != REQ_NONE)
                    items++;
            end
        end
        wait_for_results();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idling = 1'b1;
        recv_idling = 1'b1;
        test_empty_and_classes();
        test_default_drop_age();
        test_full_queue();
        test_drop_age_limits();
        test_backpressure();
        test_random();
        if (fail_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #10_000_000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/pqad_pkg.sv
hdl/pqad_ram.sv
hdl/priority_queue_age_drop.sv
tb/testbench.sv
